// ===== sv/tcpop_pkg.sv =====
package tcpop_pkg;

	typedef enum logic [3:0] {
		REC_END       = 4'd0,
		REC_EOL       = 4'd1,
		REC_NOP       = 4'd2,
		REC_MSS       = 4'd3,
		REC_WSCALE    = 4'd4,
		REC_TIMESTAMP = 4'd5,
		REC_SACK_OK   = 4'd6,
		REC_SACK_EDGE = 4'd7,
		REC_UNKNOWN   = 4'd8,
		REC_TRUNCATED = 4'd9
	} rec_kind_t;

	// option kind bytes
	localparam logic [7:0] KIND_EOL    = 8'd0;
	localparam logic [7:0] KIND_NOP    = 8'd1;
	localparam logic [7:0] KIND_MSS    = 8'd2;
	localparam logic [7:0] KIND_WS     = 8'd3;
	localparam logic [7:0] KIND_SACKOK = 8'd4;
	localparam logic [7:0] KIND_SACK   = 8'd5;
	localparam logic [7:0] KIND_TS     = 8'd8;

	// option lengths
	localparam logic [7:0] LEN_HDR      = 8'd2;
	localparam logic [7:0] LEN_MSS      = 8'd4;
	localparam logic [7:0] LEN_WS       = 8'd3;
	localparam logic [7:0] LEN_TS       = 8'd10;
	localparam logic [7:0] LEN_SACK_KIND = 8'd3;
	localparam logic [7:0] LEN_SACK_MIN = 8'd10;
	localparam logic [7:0] PAIR_BYTES   = 8'd8;

	// byte positions inside fixed options
	localparam logic [7:0] POS_MSS_LAST = 8'd3;
	localparam logic [7:0] POS_WS_LAST  = 8'd2;
	localparam logic [7:0] POS_TS_HELD  = 8'd5;
	localparam logic [7:0] POS_TS_LAST  = 8'd9;

	// offsets inside one SACK edge pair
	localparam logic [2:0] PAIR_START = 3'd0;
	localparam logic [2:0] PAIR_HELD  = 3'd3;
	localparam logic [2:0] PAIR_LAST  = 3'd7;

	typedef struct packed {
		rec_kind_t   kind;
		logic [7:0]  code;
		logic [7:0]  length;
		logic [31:0] first;
		logic [31:0] second;
		logic        done;
	} rec_t;

endpackage

// ===== sv/tcpop_in_if.sv =====
interface tcpop_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] option_byte;
	logic [5:0] bytes_left;

	modport source (output valid, output option_byte, output bytes_left, input ready);
	modport sink (input valid, input option_byte, input bytes_left, output ready);
endinterface

// ===== sv/tcpop_out_if.sv =====
interface tcpop_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  record_kind;
	logic [7:0]  option_code;
	logic [7:0]  option_length;
	logic [31:0] first_value;
	logic [31:0] second_value;
	logic        area_done;

	modport source (output valid, output record_kind, output option_code,
		output option_length, output first_value, output second_value,
		output area_done, input ready);
	modport sink (input valid, input record_kind, input option_code,
		input option_length, input first_value, input second_value,
		input area_done, output ready);
endinterface

// ===== sv/tcp_option_parser_top.sv =====
// TCP options parser: takes one option byte per cycle on the options channel
// while the queue has room, each tagged with the count of bytes left in the
// area, and gives decoded records (EOL, NOP, MSS, window scale, timestamps,
// SACK-permitted, one record per SACK edge pair, unknown, truncated) on the
// records channel. A record appears on the last byte of its option or pair,
// or on the byte that shows a truncation; bytes that end no option give no
// record. The parse state registers close their loop on each byte, so that
// rate is sustained. A record passes a two-word queue, then the output
// register; the options channel stalls only while that queue holds two words.
module tcp_option_parser_top #(
	parameter int MAX_OPTION_BYTES = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	tcpop_in_if.sink    options,
	tcpop_out_if.source records
);

	logic            space, push, pop, pop_valid;
	tcpop_pkg::rec_t push_rec, pop_rec;

	tcpop_front #(
		.MAX_OPTION_BYTES(MAX_OPTION_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.opt_in   (options),
		.space    (space),
		.push     (push),
		.push_rec (push_rec)
	);

	tcpop_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.space     (space),
		.pop_valid (pop_valid),
		.pop_rec   (pop_rec),
		.pop       (pop)
	);

	tcpop_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_rec   (pop_rec),
		.pop       (pop),
		.rec_out   (records)
	);

endmodule

// ===== sv/tcpop_front.sv =====
module tcpop_front #(
	parameter int MAX_OPTION_BYTES = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	tcpop_in_if.sink         opt_in,
	input  logic             space,
	output logic             push,
	output tcpop_pkg::rec_t  push_rec
);

	localparam logic [7:0] MaxBytes = 8'(MAX_OPTION_BYTES);

	logic [7:0]  pos_q, kind_q, len_q;
	logic [31:0] acc_q, held_q;
	logic        stopped_q;

	logic [7:0]  pos_n, kind_n, len_n;
	logic [31:0] acc_n, held_n;
	logic        stop_n;

	logic [7:0]  b, left_c, need, lenout, pos_sub, len_rest;
	logic [8:0]  left_p1, pos_p1;
	logic        last, trunc, fin, hit, accept;
	logic [2:0]  pair_ofs;
	logic [31:0] v1, v2;
	tcpop_pkg::rec_kind_t kind_c;

	assign opt_in.ready = space;
	assign accept = opt_in.valid && space;
	assign b = opt_in.option_byte;

	always_comb begin
		left_c = ({2'b00, opt_in.bytes_left} > MaxBytes) ? MaxBytes : {2'b00, opt_in.bytes_left};
		last = (left_c <= 8'd1);
		left_p1 = {1'b0, left_c} + 9'd1;
		pos_p1 = {1'b0, pos_q} + 9'd1;
		pos_sub = pos_q - tcpop_pkg::LEN_HDR;
		pair_ofs = pos_sub[2:0];
		len_rest = len_q - pos_q;

		pos_n = pos_q;
		kind_n = kind_q;
		len_n = len_q;
		acc_n = acc_q;
		held_n = held_q;
		stop_n = stopped_q;
		need = tcpop_pkg::LEN_HDR;
		hit = 1'b0;
		kind_c = tcpop_pkg::REC_END;
		v1 = '0;
		v2 = '0;
		trunc = 1'b0;
		fin = 1'b0;
		lenout = '0;

		if (stopped_q) begin
			// swallow the rest of the area
			if (last) begin
				pos_n = '0;
				kind_n = '0;
				len_n = '0;
				acc_n = '0;
				held_n = '0;
				stop_n = 1'b0;
			end
		end else begin
			if (pos_q == 8'd0) begin
				kind_n = b;
				len_n = '0;
				if (b == tcpop_pkg::KIND_EOL) begin
					hit = 1'b1;
					kind_c = tcpop_pkg::REC_EOL;
					fin = 1'b1;
				end else if (b == tcpop_pkg::KIND_NOP) begin
					hit = 1'b1;
					kind_c = tcpop_pkg::REC_NOP;
					fin = 1'b1;
				end else begin
					case (b)
						tcpop_pkg::KIND_MSS:  need = tcpop_pkg::LEN_MSS;
						tcpop_pkg::KIND_WS:   need = tcpop_pkg::LEN_WS;
						tcpop_pkg::KIND_TS:   need = tcpop_pkg::LEN_TS;
						tcpop_pkg::KIND_SACK: need = tcpop_pkg::LEN_SACK_KIND;
						default:              need = tcpop_pkg::LEN_HDR;
					endcase
					if (left_c < need)
						trunc = 1'b1;
				end
			end else if (pos_q == 8'd1) begin
				len_n = b;
				acc_n = '0;
				held_n = '0;
				case (kind_q)
					tcpop_pkg::KIND_MSS: trunc = (b != tcpop_pkg::LEN_MSS);
					tcpop_pkg::KIND_WS:  trunc = (b != tcpop_pkg::LEN_WS);
					tcpop_pkg::KIND_TS:  trunc = (b != tcpop_pkg::LEN_TS);
					tcpop_pkg::KIND_SACKOK: begin
						if (b != tcpop_pkg::LEN_HDR) begin
							trunc = 1'b1;
						end else begin
							hit = 1'b1;
							kind_c = tcpop_pkg::REC_SACK_OK;
							fin = 1'b1;
						end
					end
					tcpop_pkg::KIND_SACK: begin
						// need at least one full pair inside the area
						trunc = (b < tcpop_pkg::LEN_SACK_MIN) || ({1'b0, b} > left_p1);
					end
					default: begin
						if ((b < tcpop_pkg::LEN_HDR) || ({1'b0, b} > left_p1)) begin
							trunc = 1'b1;
						end else if (b == tcpop_pkg::LEN_HDR) begin
							hit = 1'b1;
							kind_c = tcpop_pkg::REC_UNKNOWN;
							fin = 1'b1;
						end
					end
				endcase
			end else begin
				acc_n = {acc_q[23:0], b};
				case (kind_q)
					tcpop_pkg::KIND_MSS: begin
						if (pos_q == tcpop_pkg::POS_MSS_LAST) begin
							hit = 1'b1;
							kind_c = tcpop_pkg::REC_MSS;
							v1 = {16'd0, acc_n[15:0]};
						end
					end
					tcpop_pkg::KIND_WS: begin
						if (pos_q == tcpop_pkg::POS_WS_LAST) begin
							hit = 1'b1;
							kind_c = tcpop_pkg::REC_WSCALE;
							v1 = {24'd0, b};
						end
					end
					tcpop_pkg::KIND_TS: begin
						if (pos_q == tcpop_pkg::POS_TS_HELD) begin
							held_n = acc_n;
						end else if (pos_q == tcpop_pkg::POS_TS_LAST) begin
							hit = 1'b1;
							kind_c = tcpop_pkg::REC_TIMESTAMP;
							v1 = held_q;
							v2 = acc_n;
						end
					end
					tcpop_pkg::KIND_SACK: begin
						// a pair start with less than a pair left is a short tail
						if ((pair_ofs == tcpop_pkg::PAIR_START) && (len_q >= pos_q)
								&& (len_rest < tcpop_pkg::PAIR_BYTES)) begin
							trunc = 1'b1;
						end else if (pair_ofs == tcpop_pkg::PAIR_HELD) begin
							held_n = acc_n;
						end else if (pair_ofs == tcpop_pkg::PAIR_LAST) begin
							hit = 1'b1;
							kind_c = tcpop_pkg::REC_SACK_EDGE;
							v1 = held_q;
							v2 = acc_n;
						end
					end
					default: begin
						if (pos_p1 == {1'b0, len_q}) begin
							hit = 1'b1;
							kind_c = tcpop_pkg::REC_UNKNOWN;
						end
					end
				endcase
				if (pos_p1 >= {1'b0, len_q})
					fin = 1'b1;
			end

			if (last && !fin)
				trunc = 1'b1;
			if (trunc) begin
				hit = 1'b1;
				kind_c = tcpop_pkg::REC_TRUNCATED;
				v1 = '0;
				v2 = '0;
				fin = 1'b0;
				stop_n = 1'b1;
			end
			if (pos_q != 8'd0)
				lenout = len_n;

			pos_n = fin ? 8'd0 : pos_p1[7:0];

			if (last) begin
				pos_n = '0;
				kind_n = '0;
				len_n = '0;
				acc_n = '0;
				held_n = '0;
				stop_n = 1'b0;
			end
		end
	end

	assign push = accept && !stopped_q && hit;
	// take the kind byte from the input on a kind byte, else from state
	assign push_rec = '{kind: kind_c, code: (pos_q == 8'd0) ? b : kind_q, length: lenout,
		first: v1, second: v2, done: last || trunc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			kind_q <= '0;
			len_q <= '0;
			acc_q <= '0;
			held_q <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			pos_q <= pos_n;
			kind_q <= kind_n;
			len_q <= len_n;
			acc_q <= acc_n;
			held_q <= held_n;
			stopped_q <= stop_n;
		end
	end

endmodule

// ===== sv/tcpop_queue.sv =====
module tcpop_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tcpop_pkg::rec_t  push_rec,
	output logic             space,
	output logic             pop_valid,
	output tcpop_pkg::rec_t  pop_rec,
	input  logic             pop
);

	tcpop_pkg::rec_t mem_q [2];
	logic [1:0] count_q;
	logic       wr_q, rd_q;
	logic       do_push, do_pop;

	assign space = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_rec = mem_q[rd_q];
	assign do_push = push && space;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (do_push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/tcpop_back.sv =====
module tcpop_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  tcpop_pkg::rec_t  pop_rec,
	output logic             pop,
	tcpop_out_if.source      rec_out
);

	logic            valid_q;
	tcpop_pkg::rec_t rec_q;

	// reload whenever the output word is empty or leaving
	assign pop = pop_valid && (!valid_q || rec_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || rec_out.ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= pop_rec;
	end

	assign rec_out.valid = valid_q;
	assign rec_out.record_kind = rec_q.kind;
	assign rec_out.option_code = rec_q.code;
	assign rec_out.option_length = rec_q.length;
	assign rec_out.first_value = rec_q.first;
	assign rec_out.second_value = rec_q.second;
	assign rec_out.area_done = rec_q.done;

endmodule

// ===== verif/tb_tcp_option_parser_top.sv =====
`timescale 1ns / 100ps

module tb_tcp_option_parser_top;

	localparam int MAX_AREA_BYTES = 40;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tcpop_in_if  option_bus();
	tcpop_out_if record_bus();

	tcp_option_parser_top #(
		.MAX_OPTION_BYTES(MAX_AREA_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.options(option_bus),
		.records(record_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parse state of the expected behavior
	logic [7:0]  opt_pos;
	logic [7:0]  opt_kind;
	int unsigned opt_len;
	logic [31:0] data_shift;
	logic [31:0] data_held;
	bit          area_halted;

	tcpop_pkg::rec_t pending_records[$];
	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   send_idle_pct = 0;
	int   record_stall_pct = 0;

	function automatic void clear_parse();
		opt_pos = '0;
		opt_kind = '0;
		opt_len = 0;
		data_shift = '0;
		data_held = '0;
		area_halted = 1'b0;
	endfunction

	// returns 1 when the byte completes a record
	function automatic bit decode_option_byte(input logic [7:0] b, input logic [5:0] left_raw,
		output tcpop_pkg::rec_t rec);
		int unsigned left;
		int unsigned pos;
		int unsigned need;
		int unsigned pair_ofs;
		int unsigned blen;
		bit last;
		bit trunc;
		bit finished;
		bit emit;
		tcpop_pkg::rec_kind_t kind;
		logic [31:0] v1;
		logic [31:0] v2;
		logic [7:0] len_out;

		left = left_raw;
		if (left > MAX_AREA_BYTES)
			left = MAX_AREA_BYTES;
		last = (left <= 1);
		trunc = 1'b0;
		finished = 1'b0;
		emit = 1'b0;
		kind = tcpop_pkg::REC_END;
		v1 = '0;
		v2 = '0;
		rec = '0;
		blen = b;

		// ignore the rest of an abandoned area
		if (area_halted) begin
			if (last)
				clear_parse();
			return 1'b0;
		end

		if (opt_pos == 8'd0) begin
			opt_kind = b;
			opt_len = 0;
			if (b == tcpop_pkg::KIND_EOL) begin
				kind = tcpop_pkg::REC_EOL;
				emit = 1'b1;
				finished = 1'b1;
			end else if (b == tcpop_pkg::KIND_NOP) begin
				kind = tcpop_pkg::REC_NOP;
				emit = 1'b1;
				finished = 1'b1;
			end else begin
				case (b)
					tcpop_pkg::KIND_MSS:  need = tcpop_pkg::LEN_MSS;
					tcpop_pkg::KIND_WS:   need = tcpop_pkg::LEN_WS;
					tcpop_pkg::KIND_TS:   need = tcpop_pkg::LEN_TS;
					tcpop_pkg::KIND_SACK: need = tcpop_pkg::LEN_SACK_KIND;
					default:              need = tcpop_pkg::LEN_HDR;
				endcase
				if (left < need)
					trunc = 1'b1;
			end
		end else if (opt_pos == 8'd1) begin
			opt_len = blen;
			data_shift = '0;
			data_held = '0;
			case (opt_kind)
				tcpop_pkg::KIND_MSS: if (b != tcpop_pkg::LEN_MSS) trunc = 1'b1;
				tcpop_pkg::KIND_WS:  if (b != tcpop_pkg::LEN_WS) trunc = 1'b1;
				tcpop_pkg::KIND_TS:  if (b != tcpop_pkg::LEN_TS) trunc = 1'b1;
				tcpop_pkg::KIND_SACKOK: begin
					if (b != tcpop_pkg::LEN_HDR) begin
						trunc = 1'b1;
					end else begin
						kind = tcpop_pkg::REC_SACK_OK;
						emit = 1'b1;
						finished = 1'b1;
					end
				end
				tcpop_pkg::KIND_SACK: begin
					if (blen <= tcpop_pkg::LEN_HDR || blen > left + 1
							|| blen - tcpop_pkg::LEN_HDR < tcpop_pkg::PAIR_BYTES)
						trunc = 1'b1;
				end
				default: begin
					if (blen < tcpop_pkg::LEN_HDR || blen > left + 1) begin
						trunc = 1'b1;
					end else if (blen == tcpop_pkg::LEN_HDR) begin
						kind = tcpop_pkg::REC_UNKNOWN;
						emit = 1'b1;
						finished = 1'b1;
					end
				end
			endcase
		end else begin
			pos = opt_pos;
			data_shift = {data_shift[23:0], b};
			case (opt_kind)
				tcpop_pkg::KIND_MSS: begin
					if (pos == tcpop_pkg::POS_MSS_LAST) begin
						kind = tcpop_pkg::REC_MSS;
						emit = 1'b1;
						v1 = {16'h0000, data_shift[15:0]};
					end
				end
				tcpop_pkg::KIND_WS: begin
					if (pos == tcpop_pkg::POS_WS_LAST) begin
						kind = tcpop_pkg::REC_WSCALE;
						emit = 1'b1;
						v1 = {24'h000000, b};
					end
				end
				tcpop_pkg::KIND_TS: begin
					if (pos == tcpop_pkg::POS_TS_HELD) begin
						data_held = data_shift;
					end else if (pos == tcpop_pkg::POS_TS_LAST) begin
						kind = tcpop_pkg::REC_TIMESTAMP;
						emit = 1'b1;
						v1 = data_held;
						v2 = data_shift;
					end
				end
				tcpop_pkg::KIND_SACK: begin
					pair_ofs = (pos - tcpop_pkg::LEN_HDR) % tcpop_pkg::PAIR_BYTES;
					// a remainder shorter than a pair dies at its first byte
					if (pair_ofs == tcpop_pkg::PAIR_START
							&& opt_len - pos < tcpop_pkg::PAIR_BYTES) begin
						trunc = 1'b1;
					end else if (pair_ofs == tcpop_pkg::PAIR_HELD) begin
						data_held = data_shift;
					end else if (pair_ofs == tcpop_pkg::PAIR_LAST) begin
						kind = tcpop_pkg::REC_SACK_EDGE;
						emit = 1'b1;
						v1 = data_held;
						v2 = data_shift;
					end
				end
				default: begin
					if (pos + 1 == opt_len) begin
						kind = tcpop_pkg::REC_UNKNOWN;
						emit = 1'b1;
					end
				end
			endcase
			if (pos + 1 >= opt_len)
				finished = 1'b1;
		end

		if (last && !finished)
			trunc = 1'b1;
		if (trunc) begin
			kind = tcpop_pkg::REC_TRUNCATED;
			emit = 1'b1;
			v1 = '0;
			v2 = '0;
			finished = 1'b0;
		end

		if (kind == tcpop_pkg::REC_EOL || kind == tcpop_pkg::REC_NOP)
			len_out = '0;
		else if (opt_pos >= 8'd1)
			len_out = opt_len[7:0];
		else
			len_out = '0;

		rec.kind = kind;
		rec.code = opt_kind;
		rec.length = len_out;
		rec.first = v1;
		rec.second = v2;
		rec.done = last || trunc;

		if (trunc)
			area_halted = 1'b1;
		if (finished)
			opt_pos = '0;
		else
			opt_pos = opt_pos + 8'd1;
		if (last)
			clear_parse();
		return emit;
	endfunction

	task automatic send_word(input logic [7:0] b, input logic [5:0] left);
		tcpop_pkg::rec_t rec;

		while ($urandom_range(99) < send_idle_pct) begin
			option_bus.valid <= 1'b0;
			@(posedge clk);
		end
		option_bus.valid <= 1'b1;
		option_bus.option_byte <= b;
		option_bus.bytes_left <= left;
		@(posedge clk);
		while (!option_bus.ready)
			@(posedge clk);
		if (decode_option_byte(b, left, rec))
			pending_records.push_back(rec);
	endtask

	// count bytes_left down to 1, or to 0 when asked
	task automatic send_area(input logic [7:0] area[$], input bit zero_last);
		int n;

		n = area.size();
		for (int i = 0; i < n; i++)
			send_word(area[i], (i == n - 1 && zero_last) ? 6'd0 : 6'(n - i));
	endtask

	task automatic wait_records_drained();
		option_bus.valid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] payload_byte();
		case ($urandom_range(3))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] unknown_kind();
		logic [7:0] k;

		k = 8'($urandom_range(6, 255));
		if (k == tcpop_pkg::KIND_TS)
			k = 8'd9;
		return k;
	endfunction

	// build one options area of the given size; broken options on request
	function automatic void build_area(ref logic [7:0] area[$], input int target,
		input bit allow_broken);
		logic [7:0] opt[$];
		int sel;
		int n;
		int tries;
		int len;

		area.delete();
		tries = 0;
		while (area.size() < target) begin
			opt.delete();
			sel = $urandom_range(allow_broken ? 9 : 7, 0);
			case (sel)
				0: opt.push_back(tcpop_pkg::KIND_EOL);
				1: opt.push_back(tcpop_pkg::KIND_NOP);
				2: begin
					opt.push_back(tcpop_pkg::KIND_MSS);
					opt.push_back(tcpop_pkg::LEN_MSS);
					repeat (2) opt.push_back(payload_byte());
				end
				3: begin
					opt.push_back(tcpop_pkg::KIND_WS);
					opt.push_back(tcpop_pkg::LEN_WS);
					opt.push_back(payload_byte());
				end
				4: begin
					opt.push_back(tcpop_pkg::KIND_SACKOK);
					opt.push_back(tcpop_pkg::LEN_HDR);
				end
				5: begin
					opt.push_back(tcpop_pkg::KIND_TS);
					opt.push_back(tcpop_pkg::LEN_TS);
					repeat (8) opt.push_back(payload_byte());
				end
				6: begin
					n = $urandom_range(1, 4);
					opt.push_back(tcpop_pkg::KIND_SACK);
					opt.push_back(8'(tcpop_pkg::LEN_HDR + tcpop_pkg::PAIR_BYTES * n));
					repeat (tcpop_pkg::PAIR_BYTES * n) opt.push_back(payload_byte());
				end
				7: begin
					len = $urandom_range(2, 10);
					opt.push_back(unknown_kind());
					opt.push_back(8'(len));
					repeat (len - 2) opt.push_back(payload_byte());
				end
				8: begin
					// SACK length that leaves a partial pair
					len = tcpop_pkg::LEN_HDR + tcpop_pkg::PAIR_BYTES * $urandom_range(0, 3)
						+ $urandom_range(1, 7);
					opt.push_back(tcpop_pkg::KIND_SACK);
					opt.push_back(8'(len));
					repeat (len - 2) opt.push_back(payload_byte());
				end
				default: begin
					case ($urandom_range(4))
						0:       opt.push_back(tcpop_pkg::KIND_MSS);
						1:       opt.push_back(tcpop_pkg::KIND_WS);
						2:       opt.push_back(tcpop_pkg::KIND_TS);
						3:       opt.push_back(tcpop_pkg::KIND_SACKOK);
						default: opt.push_back(unknown_kind());
					endcase
					opt.push_back(8'($urandom_range(0, 12)));
					repeat ($urandom_range(0, 4)) opt.push_back(payload_byte());
				end
			endcase
			if (area.size() + opt.size() <= target) begin
				foreach (opt[i]) area.push_back(opt[i]);
			end else if (tries < 4) begin
				tries++;
			end else begin
				while (area.size() < target)
					area.push_back(tcpop_pkg::KIND_NOP);
			end
		end
	endfunction

	task automatic test_fixed_options();
		logic [7:0] area[$];

		area = {tcpop_pkg::KIND_MSS, tcpop_pkg::LEN_MSS, 8'hff, 8'hff, tcpop_pkg::KIND_WS,
			tcpop_pkg::LEN_WS, 8'h0e, tcpop_pkg::KIND_EOL, tcpop_pkg::KIND_NOP,
			tcpop_pkg::KIND_SACKOK, tcpop_pkg::LEN_HDR};
		send_area(area, 1'b0);
		area = {tcpop_pkg::KIND_MSS, tcpop_pkg::LEN_MSS, 8'h00, 8'h00};
		send_area(area, 1'b0);
	endtask

	task automatic test_timestamp_and_sack();
		logic [7:0] area[$];

		area = {tcpop_pkg::KIND_TS, tcpop_pkg::LEN_TS, 8'hff, 8'hff, 8'hff, 8'hff,
			8'h00, 8'h00, 8'h00, 8'h01};
		send_area(area, 1'b0);
		// one full pair, then a three byte remainder
		area = {tcpop_pkg::KIND_SACK, 8'd13, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h11, 8'h22, 8'h33};
		send_area(area, 1'b0);
	endtask

	task automatic test_truncations();
		logic [7:0] area[$];

		area = {tcpop_pkg::KIND_MSS, 8'd5, 8'h12};
		send_area(area, 1'b0);
		area = {8'd99, 8'd1};
		send_area(area, 1'b0);
		area = {tcpop_pkg::KIND_TS};
		send_area(area, 1'b0);
		area = {tcpop_pkg::KIND_WS, tcpop_pkg::LEN_WS};
		send_area(area, 1'b0);
		area = {8'd200, 8'd9, 8'h00};
		send_area(area, 1'b0);
	endtask

	task automatic test_bytes_left_limits();
		send_word(tcpop_pkg::KIND_NOP, 6'd63);
		send_word(tcpop_pkg::KIND_EOL, 6'd0);
		send_word(tcpop_pkg::KIND_NOP, 6'd0);
	endtask

	task automatic test_random_traffic(input int budget, input int src_pct, input int snk_pct);
		logic [7:0] area[$];
		int sent;
		int mode;
		int n;
		int target;

		send_idle_pct = src_pct;
		record_stall_pct = snk_pct;
		sent = 0;
		while (sent < budget) begin
			mode = $urandom_range(99);
			if (mode < 10) begin
				// noise, closed by a last byte
				n = $urandom_range(1, 8);
				repeat (n) send_word(8'($urandom_range(255)), 6'($urandom_range(63)));
				send_word(8'($urandom_range(255)), 6'd1);
				sent += n + 1;
			end else begin
				if (mode < 15)
					target = $urandom_range(MAX_AREA_BYTES + 1, 63);
				else if ($urandom_range(3) == 0)
					target = $urandom_range(24, MAX_AREA_BYTES);
				else
					target = $urandom_range(1, 20);
				build_area(area, target, mode >= 75);
				if (mode >= 90 && area.size() > 1)
					area = area[0:$urandom_range(0, area.size() - 2)];
				else if (mode >= 85)
					area[$urandom_range(area.size() - 1)] = 8'($urandom_range(255));
				send_area(area, $urandom_range(3) == 0);
				sent += area.size();
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[tcp_option_parser_top] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin : check_records
		tcpop_pkg::rec_t want;

		if (arst_n && record_bus.valid && record_bus.ready) begin
			if (pending_records.size() == 0) begin
				$error("record_kind: no record expected, got %0d", record_bus.record_kind);
				mismatch_count++;
			end else begin
				want = pending_records.pop_front();
				if (want.kind !== record_bus.record_kind) begin
					$error("record_kind: expected %0d, got %0d", want.kind,
						record_bus.record_kind);
					mismatch_count++;
				end
				if (want.code !== record_bus.option_code) begin
					$error("option_code: expected %0d, got %0d", want.code,
						record_bus.option_code);
					mismatch_count++;
				end
				if (want.length !== record_bus.option_length) begin
					$error("option_length: expected %0d, got %0d", want.length,
						record_bus.option_length);
					mismatch_count++;
				end
				if (want.first !== record_bus.first_value) begin
					$error("first_value: expected %h, got %h", want.first,
						record_bus.first_value);
					mismatch_count++;
				end
				if (want.second !== record_bus.second_value) begin
					$error("second_value: expected %h, got %h", want.second,
						record_bus.second_value);
					mismatch_count++;
				end
				if (want.done !== record_bus.area_done) begin
					$error("area_done: expected %0d, got %0d", want.done,
						record_bus.area_done);
					mismatch_count++;
				end
			end
		end
		record_bus.ready <= ($urandom_range(99) >= record_stall_pct);
	end

	initial begin
		option_bus.valid <= 1'b0;
		option_bus.option_byte <= '0;
		option_bus.bytes_left <= '0;
		clear_parse();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fixed_options();
		test_timestamp_and_sack();
		test_truncations();
		test_bytes_left_limits();
		wait_records_drained();

		test_random_traffic(260, 0, 0);
		wait_records_drained();
		test_random_traffic(260, 60, 0);
		wait_records_drained();
		test_random_traffic(260, 0, 60);
		wait_records_drained();
		test_random_traffic(260, 29, 29);
		wait_records_drained();

		if (mismatch_count == 0)
			$display("[tcp_option_parser_top] OK");
		else
			$display("[tcp_option_parser_top] ERROR");
		$finish;
	end

endmodule

// ===== tcp_option_parser_top.f =====
sv/tcpop_pkg.sv
sv/tcpop_in_if.sv
sv/tcpop_out_if.sv
sv/tcpop_front.sv
sv/tcpop_queue.sv
sv/tcpop_back.sv
sv/tcp_option_parser_top.sv
verif/tb_tcp_option_parser_top.sv
